// ===== rtl/core/bef_pkg.sv =====
// Shared constants and types for the binary entropy pipeline.
`default_nettype none
package bef_pkg;
	localparam int unsigned LOG_FRAC   = 40;
	localparam int unsigned LOG_INT    = 6;
	localparam int unsigned LOG_W      = LOG_INT + LOG_FRAC;
	localparam int unsigned MANT_W     = 63;
	localparam int unsigned P_FRAC     = 62;
	localparam int unsigned P_W        = P_FRAC + 1;
	localparam int unsigned TERM_FRAC  = 48;
	localparam int unsigned TERM_SHIFT = P_FRAC + LOG_FRAC - TERM_FRAC;
	localparam int unsigned TERM_W     = 55;
	localparam int unsigned RATIO_W    = 32;
	localparam int unsigned ENT_W      = 32;
	localparam int unsigned LOG_LAT    = 1 + 2 * LOG_FRAC;
	localparam int unsigned DIV_LAT    = P_FRAC + 1;
	localparam int unsigned TERM_LAT   = 3;

	typedef logic [LOG_W-1:0]  log_t;
	typedef logic [P_W-1:0]    prob_t;
	typedef logic [TERM_W-1:0] term_t;

	typedef struct packed {
		logic bad;
		logic z_on;
		logic o_on;
	} flags_t;
endpackage
`default_nettype wire

// ===== rtl/core/bef_ifs.sv =====
// Stream interfaces for count triples and entropy results.
`default_nettype none
interface bef_in_if #(parameter int unsigned CW = 32);
	logic          valid;
	logic          ready;
	logic [CW-1:0] total_count;
	logic [CW-1:0] zero_count;
	logic [CW-1:0] one_count;
	modport source(output valid, total_count, zero_count, one_count, input ready);
	modport sink(input valid, total_count, zero_count, one_count, output ready);
endinterface

interface bef_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] zero_ratio;
	logic [31:0] entropy_bits;
	logic        invalid;
	modport source(output valid, zero_ratio, entropy_bits, invalid, input ready);
	modport sink(input valid, zero_ratio, entropy_bits, invalid, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bef_log2.sv =====
// Pipelined log2 of an integer: normalize, then one fraction bit per squaring step.
`default_nettype none
module bef_log2 #(
	parameter int unsigned CW = 32
) (
	input  logic          clk,
	input  logic          adv,
	input  logic [CW-1:0] x,
	output bef_pkg::log_t y
);
	import bef_pkg::*;

	localparam logic [LOG_INT-1:0] TOP_BIT = LOG_INT'(MANT_W - 1);

	logic [LOG_INT-1:0]  e_c;
	logic [MANT_W-1:0]   m_c;
	logic [MANT_W-1:0]   m_s [0:LOG_FRAC-1];
	logic [LOG_INT-1:0]  e_s [0:LOG_FRAC];
	logic [LOG_FRAC-1:0] f_s [0:LOG_FRAC];

	// leading one position and Q1.62 mantissa
	always_comb begin
		e_c = '0;
		for (int i = 0; i < CW; i++) begin
			if (x[i]) e_c = LOG_INT'(i);
		end
		m_c = MANT_W'(x) << (TOP_BIT - e_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s[0] <= m_c;
			e_s[0] <= e_c;
			f_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
		logic [61:0]         hh_s;
		logic [62:0]         hl_s;
		logic [63:0]         ll_s;
		logic [LOG_INT-1:0]  ea_s;
		logic [LOG_FRAC-1:0] fa_s;
		logic [125:0]        sq_c;
		logic [63:0]         sh_c;

		// partial products of the square
		always_ff @(posedge clk) begin
			if (adv) begin
				hh_s <= m_s[k][62:32] * m_s[k][62:32];
				hl_s <= m_s[k][62:32] * m_s[k][31:0];
				ll_s <= m_s[k][31:0] * m_s[k][31:0];
				ea_s <= e_s[k];
				fa_s <= f_s[k];
			end
		end

		always_comb begin
			sq_c = {hh_s, 64'd0} + {30'd0, hl_s, 33'd0} + {62'd0, ll_s};
			sh_c = sq_c[125:62];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				e_s[k+1] <= ea_s;
				f_s[k+1] <= {fa_s[LOG_FRAC-2:0], sh_c[63]};
			end
		end

		if (k + 1 < LOG_FRAC) begin : g_mant
			always_ff @(posedge clk) begin
				if (adv) m_s[k+1] <= sh_c[63] ? sh_c[63:1] : sh_c[62:0];
			end
		end
	end

	assign y = {e_s[LOG_FRAC], f_s[LOG_FRAC]};
endmodule
`default_nettype wire

// ===== rtl/core/bef_div.sv =====
// Pipelined restoring divider: floor(num * 2^62 / den), one quotient bit per stage.
`default_nettype none
module bef_div #(
	parameter int unsigned CW = 32
) (
	input  logic           clk,
	input  logic           adv,
	input  logic [CW-1:0]  num,
	input  logic [CW-1:0]  den,
	output bef_pkg::prob_t quo
);
	import bef_pkg::*;

	localparam int unsigned PAD = LOG_LAT - DIV_LAT;

	logic [CW-1:0] d_s [0:P_FRAC-1];
	logic [CW-1:0] r_s [0:P_FRAC-1];
	prob_t         q_s [0:P_FRAC];
	prob_t         dl_s [0:PAD-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s[0] <= den;
			r_s[0] <= (num >= den) ? num - den : num;
			q_s[0] <= P_W'(num >= den);
		end
	end

	for (genvar k = 0; k < P_FRAC; k++) begin : g_step
		logic [CW:0] r2_c;
		logic        ge_c;

		always_comb begin
			r2_c = {r_s[k], 1'b0};
			ge_c = r2_c >= {1'b0, d_s[k]};
		end

		always_ff @(posedge clk) begin
			if (adv) q_s[k+1] <= {q_s[k][P_W-2:0], ge_c};
		end

		if (k + 1 < P_FRAC) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					d_s[k+1] <= d_s[k];
					r_s[k+1] <= ge_c ? CW'(r2_c - {1'b0, d_s[k]}) : CW'(r2_c);
				end
			end
		end
	end

	// line up with the log2 latency
	always_ff @(posedge clk) begin
		if (adv) begin
			dl_s[0] <= q_s[P_FRAC];
			for (int j = 1; j < PAD; j++) dl_s[j] <= dl_s[j-1];
		end
	end

	assign quo = dl_s[PAD-1];
endmodule
`default_nettype wire

// ===== rtl/core/bef_term.sv =====
// One entropy term: p * clamp(log2 t - log2 c) >> 54, three stages.
`default_nettype none
module bef_term (
	input  logic           clk,
	input  logic           adv,
	input  bef_pkg::log_t  lt,
	input  bef_pkg::log_t  lc,
	input  bef_pkg::prob_t p,
	output bef_pkg::term_t term
);
	import bef_pkg::*;

	log_t         l_s1;
	prob_t        p_s1;
	logic [44:0]  hh_s2;
	logic [62:0]  hl_s2;
	logic [45:0]  lh_s2;
	logic [63:0]  ll_s2;
	logic [109:0] full_c;
	term_t        term_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s1  <= (lt > lc) ? lt - lc : '0;
			p_s1  <= p;
			hh_s2 <= p_s1[62:32] * l_s1[45:32];
			hl_s2 <= p_s1[62:32] * l_s1[31:0];
			lh_s2 <= p_s1[31:0] * l_s1[45:32];
			ll_s2 <= p_s1[31:0] * l_s1[31:0];
			term_s3 <= full_c[TERM_SHIFT+TERM_W-1:TERM_SHIFT];
		end
	end

	always_comb begin
		full_c = {1'b0, hh_s2, 64'd0} + {15'd0, hl_s2, 32'd0}
			+ {32'd0, lh_s2, 32'd0} + {46'd0, ll_s2};
	end

	assign term = term_s3;
endmodule
`default_nettype wire

// ===== rtl/core/binary_entropy_from_counts.sv =====
// Top level: binary Shannon entropy and zero ratio from bit counts.
// Throughput: one triple per cycle unless the result side stalls; the 40 squaring steps of
// log2 (two stages each) set the depth, and the dividers are padded to match.
// A stall on the result side freezes the whole pipeline, nothing is lost.
// Reset clears the valid bits only; data registers are not reset.
`default_nettype none
module binary_entropy_from_counts #(
	parameter int unsigned COUNT_BITS = 32,
	parameter int unsigned FRAC_BITS  = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	bef_in_if.sink      counts,
	bef_out_if.source   result
);
	import bef_pkg::*;

	localparam int unsigned RND_SH   = TERM_FRAC - FRAC_BITS;
	localparam int unsigned SUM_W    = TERM_W + 2;
	localparam int unsigned FLAG_LAT = LOG_LAT + TERM_LAT;
	localparam logic [SUM_W-1:0] RND_ONE = SUM_W'(1) << (RND_SH - 1);

	// global advance: move everything when the output slot is free or being taken
	logic adv;

	logic [COUNT_BITS-1:0] t_s1, z_s1, o_s1;
	logic [FLAG_LAT:0]     vld_s;
	flags_t                fl_c;
	flags_t                fl_s [0:FLAG_LAT-1];

	log_t  lt, lz, lo;
	prob_t pz, po;
	term_t tz, to;
	logic [RATIO_W-1:0] rat_s [0:TERM_LAT-1];

	logic [SUM_W-1:0] sum_c;
	logic [SUM_W-1:0] h_c;
	logic [ENT_W-1:0] ent_c;

	logic               out_vld_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [ENT_W-1:0]   ent_q;
	logic               bad_q;

	assign adv          = !out_vld_q || result.ready;
	assign counts.ready = adv;

	// input register; counts taken in their low COUNT_BITS bits
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= counts.total_count[COUNT_BITS-1:0];
			z_s1 <= counts.zero_count[COUNT_BITS-1:0];
			o_s1 <= counts.one_count[COUNT_BITS-1:0];
		end
	end

	// rejected triple, and which terms contribute (zero count or full count give 0)
	always_comb begin
		fl_c.bad  = (t_s1 == '0) || (z_s1 > t_s1) || (o_s1 > t_s1);
		fl_c.z_on = (z_s1 != '0) && (z_s1 < t_s1);
		fl_c.o_on = (o_s1 != '0) && (o_s1 < t_s1);
	end

	bef_log2 #(.CW(COUNT_BITS)) u_log_t (.clk(clk), .adv(adv), .x(t_s1), .y(lt));
	bef_log2 #(.CW(COUNT_BITS)) u_log_z (.clk(clk), .adv(adv), .x(z_s1), .y(lz));
	bef_log2 #(.CW(COUNT_BITS)) u_log_o (.clk(clk), .adv(adv), .x(o_s1), .y(lo));

	bef_div #(.CW(COUNT_BITS)) u_div_z (
		.clk(clk), .adv(adv), .num(z_s1), .den(t_s1), .quo(pz)
	);
	bef_div #(.CW(COUNT_BITS)) u_div_o (
		.clk(clk), .adv(adv), .num(o_s1), .den(t_s1), .quo(po)
	);

	bef_term u_term_z (.clk(clk), .adv(adv), .lt(lt), .lc(lz), .p(pz), .term(tz));
	bef_term u_term_o (.clk(clk), .adv(adv), .lt(lt), .lc(lo), .p(po), .term(to));

	// valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s     <= {vld_s[FLAG_LAT-1:0], counts.valid};
			out_vld_q <= vld_s[FLAG_LAT];
		end
	end

	// flag and ratio delay lines; ratio is the top 32 bits of the Q1.62 quotient
	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s[0] <= fl_c;
			for (int j = 1; j < FLAG_LAT; j++) fl_s[j] <= fl_s[j-1];
			rat_s[0] <= pz[P_W-1:P_W-RATIO_W];
			for (int j = 1; j < TERM_LAT; j++) rat_s[j] <= rat_s[j-1];
		end
	end

	// sum of terms, round half up, saturate
	always_comb begin
		sum_c = (fl_s[FLAG_LAT-1].z_on ? SUM_W'(tz) : '0)
			+ (fl_s[FLAG_LAT-1].o_on ? SUM_W'(to) : '0) + RND_ONE;
		h_c   = sum_c >> RND_SH;
		ent_c = (|h_c[SUM_W-1:ENT_W]) ? '1 : h_c[ENT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_q   <= fl_s[FLAG_LAT-1].bad;
			ratio_q <= fl_s[FLAG_LAT-1].bad ? '0 : rat_s[TERM_LAT-1];
			ent_q   <= fl_s[FLAG_LAT-1].bad ? '0 : ent_c;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.zero_ratio   = ratio_q;
	assign result.entropy_bits = ent_q;
	assign result.invalid      = bad_q;
endmodule
`default_nettype wire

// ===== rtl/core/bef_chk.sv =====
// Port-level checks for the entropy block, bound to the top level.
`default_nettype none
module bef_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] zero_ratio,
	input logic [31:0] entropy_bits,
	input logic        invalid
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(zero_ratio)
			&& $stable(entropy_bits) && $stable(invalid))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output slot");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> zero_ratio == 32'd0 && entropy_bits == 32'd0)
		else $error("rejected triple with nonzero results");

	a_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> zero_ratio <= 32'h8000_0000)
		else $error("zero ratio above one");
endmodule

bind binary_entropy_from_counts bef_chk u_bef_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(counts.valid),
	.in_ready(counts.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.zero_ratio(result.zero_ratio),
	.entropy_bits(result.entropy_bits),
	.invalid(result.invalid)
);
`default_nettype wire

// ===== tb/entropy_checker.sv =====
// Checker: watches count and result transfers, predicts entropy results, compares them.
`timescale 1ns / 100ps
module entropy_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] total_count,
	input  logic [31:0] zero_count,
	input  logic [31:0] one_count,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] zero_ratio,
	input  logic [31:0] entropy_bits,
	input  logic        invalid,
	output int          fail_count,
	output int          pending,
	output int          result_count,
	output int          invalid_count
);
	import bef_pkg::*;

	typedef struct packed {
		logic [31:0] ratio;
		logic [31:0] ent;
		logic        bad;
	} entropy_result_t;

	entropy_result_t expected_results[$];

	// floor(n * 2^k / d), n <= d
	function automatic logic [63:0] frac_quotient(logic [63:0] n, logic [63:0] d, int k);
		logic [127:0] num;
		num = {64'b0, n} << k;
		return 64'(num / {64'b0, d});
	endfunction

	// log2 in Q6.40 by repeated squaring of a Q1.62 mantissa
	function automatic logic [63:0] log2_q40(logic [63:0] x);
		int msb;
		logic [63:0] m, r;
		logic [127:0] sq;
		msb = 0;
		for (int b = 0; b < 64; b++)
			if (x[b]) msb = b;
		m = (msb <= 62) ? (x << (62 - msb)) : (x >> 1);
		r = 64'(msb) << LOG_FRAC;
		for (int i = LOG_FRAC - 1; i >= 0; i--) begin
			sq = m * m;
			m = 64'(sq >> 62);
			if (m[63]) begin
				r[i] = 1'b1;
				m = m >> 1;
			end
		end
		return r;
	endfunction

	// -p*log2(p) term in Q.48
	function automatic logic [63:0] info_term(logic [63:0] c, logic [63:0] t, logic [63:0] lt);
		logic [63:0] lc, l, p;
		logic [127:0] prod;
		if (c == 0 || c >= t) return 64'd0;
		lc = log2_q40(c);
		l = (lt > lc) ? lt - lc : 64'd0;
		p = frac_quotient(c, t, P_FRAC);
		prod = p * l;
		return 64'(prod >> TERM_SHIFT);
	endfunction

	function automatic entropy_result_t predict_entropy(logic [31:0] t, logic [31:0] z,
			logic [31:0] o);
		entropy_result_t r;
		logic [63:0] lt, sum, h;
		r = '0;
		if (t == 0 || z > t || o > t) begin
			r.bad = 1'b1;
			return r;
		end
		lt = log2_q40(64'(t));
		sum = info_term(64'(z), 64'(t), lt) + info_term(64'(o), 64'(t), lt);
		h = (sum + (64'd1 << (TERM_FRAC - 30 - 1))) >> (TERM_FRAC - 30);
		r.ent = (h > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : h[31:0];
		r.ratio = 32'(frac_quotient(64'(z), 64'(t), 31));
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		entropy_result_t want, got;
		if (!arst_n) begin
			fail_count <= 0;
			result_count <= 0;
			invalid_count <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(predict_entropy(total_count, zero_count, one_count));
			if (out_valid && out_ready) begin
				got = '{zero_ratio, entropy_bits, invalid};
				result_count <= result_count + 1;
				if (invalid) invalid_count <= invalid_count + 1;
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result ratio=%h ent=%h inv=%b",
							zero_ratio, entropy_bits, invalid);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want != got) begin
						if (fail_count < 10)
							$display("ERROR: ratio %h/%h ent %h/%h inv %b/%b (exp/act)",
								want.ratio, got.ratio, want.ent, got.ent, want.bad, got.bad);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives count triples with random idling and result stalls, and reports the verdict.
`timescale 1ns / 100ps
module testbench;
	logic clk;
	logic arst_n;
	int   fail_count, pending, result_count, invalid_count;
	int   send_idle_pct, stall_pct;   // percent chance of a gap / stall per cycle

	bef_in_if  counts_if();
	bef_out_if result_if();

	binary_entropy_from_counts uut (
		.clk   (clk),
		.arst_n(arst_n),
		.counts(counts_if.sink),
		.result(result_if.source)
	);

	entropy_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (counts_if.valid),
		.in_ready     (counts_if.ready),
		.total_count  (counts_if.total_count),
		.zero_count   (counts_if.zero_count),
		.one_count    (counts_if.one_count),
		.out_valid    (result_if.valid),
		.out_ready    (result_if.ready),
		.zero_ratio   (result_if.zero_ratio),
		.entropy_bits (result_if.entropy_bits),
		.invalid      (result_if.invalid),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count),
		.invalid_count(invalid_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard limit, far beyond the slowest legal run
	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Result side: random stalls at the falling edge
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// One transfer; gaps drawn per cycle before raising valid.
	// Valid stays high after the transfer; the next gap or the caller drops it.
	task automatic send_counts(input logic [31:0] t, input logic [31:0] z, input logic [31:0] o);
		while ($urandom_range(99) < send_idle_pct) begin
			counts_if.valid <= 1'b0;
			@(negedge clk);
		end
		counts_if.valid       <= 1'b1;
		counts_if.total_count <= t;
		counts_if.zero_count  <= z;
		counts_if.one_count   <= o;
		@(posedge clk);
		while (!counts_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Random triples: mostly well formed (z+o == t), some loose, some rejected
	task automatic send_random(input int n);
		logic [31:0] t, z, o;
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99);
			case ($urandom_range(3))
				0: t = $urandom_range(20, 1);
				1: t = $urandom_range(2000, 1);
				2: t = $urandom >> $urandom_range(31);
				default: t = $urandom;
			endcase
			z = (t == 0) ? 32'd0 : $urandom_range(t, 0);
			if (kind < 70) begin
				o = t - z;
			end else if (kind < 85) begin
				o = (t == 0) ? 32'd0 : $urandom_range(t, 0);
			end else begin
				z = $urandom;
				o = $urandom;
				if (kind < 88) t = 0;
			end
			send_counts(t, z, o);
		end
	endtask

	initial begin
		counts_if.valid       = 1'b0;
		counts_if.total_count = '0;
		counts_if.zero_count  = '0;
		counts_if.one_count   = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes and each rejection / degenerate case
		send_counts(32'd1, 32'd0, 32'd1);
		send_counts(32'd1, 32'd1, 32'd0);
		send_counts(32'd2, 32'd1, 32'd1);              // maximal entropy
		send_counts(32'd0, 32'd0, 32'd0);              // zero total
		send_counts(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_counts(32'd5, 32'd6, 32'd0);              // zero count too big
		send_counts(32'd5, 32'd0, 32'd6);              // one count too big
		send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_counts(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_counts(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE);
		send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // sum far above total
		send_counts(32'h8000_0000, 32'd0, 32'd0);      // counts below total, zero entropy
		send_counts(32'd3, 32'd1, 32'd1);              // counts short of total
		send_counts(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
		send_counts(32'd1000, 32'd999, 32'd1);
		counts_if.valid <= 1'b0;

		// Sender holds off until the pipeline has drained
		wait (pending == 0);
		@(negedge clk);

		send_random(500);
		send_idle_pct = 81; stall_pct = 0;  send_random(350);
		send_idle_pct = 0;  stall_pct = 81; send_random(350);
		send_idle_pct = 26; stall_pct = 26; send_random(400);
		counts_if.valid <= 1'b0;
		send_idle_pct = 0;  stall_pct = 0;

		wait (pending == 0);
		repeat (100) @(posedge clk);

		$display("Summary: %0d results checked, %0d rejected triples, across four idling phases.",
			result_count, invalid_count);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
